/* sv/lzd_pkg.sv */
// Shared types and constants of the image line decompressor.
package lzd_pkg;

  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned RING_AW     = 10;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned COUNT_W     = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [7:0]         LIT_BIAS  = 8'd127;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BYTES_PER_LINE = 1'b0,
    REG_LINE_COUNT     = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_DATA  = 2'd0,
    STATUS_EOF   = 2'd1,
    STATUS_PHASE = 2'd2
  } status_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

endpackage

/* sv/lzd_if.sv */
// Valid/ready channels for compressed input bytes and decoded pixel results.
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface lzd_out_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          pixel_byte;
  logic                                end_of_line;
  logic                                image_done;
  lzd_pkg::status_t                    status;
  logic [lzd_pkg::COUNT_W-1:0]         consumed_bytes;
  logic                                last;

  modport source (output valid, output pixel_byte, output end_of_line, output image_done,
                  output status, output consumed_bytes, output last, input ready);
  modport sink   (input valid, input pixel_byte, input end_of_line, input image_done,
                  input status, input consumed_bytes, input last, output ready);
endinterface

/* sv/lzd_history.sv */
// History ring: one write port, one registered read port with same-cycle write forwarding.
module lzd_history (
  input  logic               clk,
  input  lzd_pkg::ring_req_t req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [lzd_pkg::RING_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] wd_q;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr];
      wd_q <= req.wdata;
      fwd  <= req.we && (req.waddr == req.raddr);
    end
  end

  assign rdata = fwd ? wd_q : rd_q;

endmodule

/* sv/lz_image_line_decompressor.sv */
// Top level: decodes literal runs and ring copies into image bytes, line by line.
// One compressed byte is taken per cycle while a code, literal or offset byte is
// expected and the output register is free; each literal byte is registered as one
// result in that cycle and appears on the next. After an offset byte the copy reads
// the 1024-byte history ring through its single registered read port; a copy codes a
// length of MIN_MATCH to 31 + MIN_MATCH bytes. A copy that crosses the line end, or a
// final literal byte that leaves the image short, ends with a separate error result.
// Output stalls pause decoding. After the image completes or any error, input bytes
// are taken and dropped until reset. The ring holds no reset value: a copy must only
// reach bytes written since reset.
module lz_image_line_decompressor #(
  parameter int unsigned MIN_MATCH = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lzd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lzd_pkg::CFG_W-1:0]        cfg_data,
  lzd_in_if.sink                           stream,
  lzd_out_if.source                        pixels
);

  localparam int unsigned MAX_LEN = 31 + MIN_MATCH;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned AW      = lzd_pkg::RING_AW;
  localparam int unsigned CW      = lzd_pkg::COUNT_W;

  typedef enum logic [5:0] {
    ST_CODE = 6'b000001,
    ST_LIT  = 6'b000010,
    ST_OFFS = 6'b000100,
    ST_COPY = 6'b001000,
    ST_TAIL = 6'b010000,
    ST_STOP = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     wp, wp_next;
  logic [7:0]        pending, pending_next;
  logic [15:0]       line_pos, line_pos_next;
  logic [15:0]       line_idx, line_idx_next;
  logic [CW-1:0]     consumed, consumed_next;
  logic [15:0]       bytes_per_line, line_count;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              cross_q, cross_next;
  logic              busy, busy_next;
  lzd_pkg::status_t  tail_status, tail_status_next;

  logic              out_valid;
  logic [7:0]        out_pix;
  logic              out_eol, out_done, out_last;
  lzd_pkg::status_t  out_status;
  logic [CW-1:0]     out_cons;

  logic              out_load;
  logic [7:0]        o_pix;
  logic              o_eol, o_done, o_last;
  lzd_pkg::status_t  o_status;

  lzd_pkg::ring_req_t req;
  logic [7:0]        rdata;

  logic              can_load, take, empty, line_full, eol_next, idx_last, done;
  logic [15:0]       lp1, room;
  logic [7:0]        pend_dec;
  logic [6:0]        code7;
  logic [CNT_W-1:0]  len;
  logic              crossing, done_after, last_byte;

  lzd_history u_history (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign can_load = !out_valid || pixels.ready;
  assign stream.ready = ((state == ST_CODE || state == ST_LIT || state == ST_OFFS) && can_load)
                        || state == ST_STOP;
  assign take      = stream.valid && stream.ready;
  assign empty     = (bytes_per_line == 16'd0) || (line_count == 16'd0);
  assign line_full = line_pos >= bytes_per_line;
  assign lp1       = line_pos + 16'd1;
  assign eol_next  = lp1 >= bytes_per_line;
  assign idx_last  = ({1'b0, line_idx} + 17'd1) >= {1'b0, line_count};
  assign pend_dec  = (pending != 8'd0) ? pending - 8'd1 : 8'd0;
  assign code7     = pending[6:0];
  assign len       = CNT_W'(code7[6:2]) + CNT_W'(MIN_MATCH);
  assign room      = line_full ? 16'd0 : bytes_per_line - line_pos;
  assign crossing  = 16'(len) > room;
  assign done_after = !crossing && (({1'b0, line_pos} + 17'(len)) >= {1'b0, bytes_per_line})
                      && idx_last;
  assign last_byte = remain == CNT_W'(1);

  always_comb begin
    state_next       = state;
    wp_next          = wp;
    pending_next     = pending;
    line_pos_next    = line_pos;
    line_idx_next    = line_idx;
    consumed_next    = consumed;
    rd_ptr_next      = rd_ptr;
    remain_next      = remain;
    cross_next       = cross_q;
    busy_next        = busy;
    tail_status_next = tail_status;
    req              = '0;
    out_load         = 1'b0;
    o_pix            = 8'd0;
    o_eol            = 1'b0;
    o_done           = 1'b0;
    o_status         = lzd_pkg::STATUS_DATA;
    o_last           = 1'b1;
    done             = 1'b0;

    unique case (state)
      ST_CODE, ST_LIT, ST_OFFS: begin
        if (take) begin
          if (empty) begin
            out_load   = 1'b1;
            o_done     = 1'b1;
            state_next = ST_STOP;
          end else begin
            consumed_next = (consumed != lzd_pkg::COUNT_MAX) ? consumed + CW'(1) : consumed;
            if (state == ST_CODE) begin
              if (stream.code_byte[7]) begin
                pending_next = stream.code_byte - lzd_pkg::LIT_BIAS;
                state_next   = ST_LIT;
              end else begin
                pending_next = stream.code_byte;
                state_next   = ST_OFFS;
              end
              if (stream.final_byte) begin
                out_load   = 1'b1;
                o_status   = lzd_pkg::STATUS_EOF;
                state_next = ST_STOP;
              end
            end else if (state == ST_LIT) begin
              if (line_full) begin
                out_load   = 1'b1;
                o_status   = lzd_pkg::STATUS_PHASE;
                state_next = ST_STOP;
              end else begin
                req.we        = 1'b1;
                req.waddr     = wp;
                req.wdata     = stream.code_byte;
                wp_next       = wp + AW'(1);
                line_pos_next = lp1;
                pending_next  = pend_dec;
                if (pend_dec == 8'd0) begin
                  state_next = ST_CODE;
                  if (eol_next) begin
                    if (idx_last) begin
                      done       = 1'b1;
                      state_next = ST_STOP;
                    end else begin
                      line_idx_next = line_idx + 16'd1;
                      line_pos_next = 16'd0;
                    end
                  end
                end
                out_load = 1'b1;
                o_pix    = stream.code_byte;
                o_eol    = eol_next;
                o_done   = done;
                o_last   = done || !stream.final_byte;
                if (!done && stream.final_byte) begin
                  tail_status_next = lzd_pkg::STATUS_EOF;
                  state_next       = ST_TAIL;
                end
              end
            end else begin
              pending_next = 8'd0;
              if (!crossing && stream.final_byte && !done_after) begin
                out_load   = 1'b1;
                o_status   = lzd_pkg::STATUS_EOF;
                state_next = ST_STOP;
              end else begin
                rd_ptr_next = wp - {code7[1:0], stream.code_byte} - AW'(1);
                remain_next = crossing ? CNT_W'(room) : len;
                cross_next  = crossing;
                busy_next   = 1'b0;
                if (crossing && room == 16'd0) begin
                  tail_status_next = lzd_pkg::STATUS_PHASE;
                  state_next       = ST_TAIL;
                end else begin
                  state_next = ST_COPY;
                end
              end
            end
          end
        end
      end
      ST_COPY: begin
        if (busy) begin
          if (can_load) begin
            req.we        = 1'b1;
            req.waddr     = wp;
            req.wdata     = rdata;
            wp_next       = wp + AW'(1);
            line_pos_next = lp1;
            remain_next   = remain - CNT_W'(1);
            if (last_byte) begin
              busy_next = 1'b0;
              if (cross_q) begin
                tail_status_next = lzd_pkg::STATUS_PHASE;
                state_next       = ST_TAIL;
              end else begin
                state_next = ST_CODE;
                if (eol_next) begin
                  if (idx_last) begin
                    done       = 1'b1;
                    state_next = ST_STOP;
                  end else begin
                    line_idx_next = line_idx + 16'd1;
                    line_pos_next = 16'd0;
                  end
                end
              end
            end else begin
              req.re      = 1'b1;
              req.raddr   = rd_ptr;
              rd_ptr_next = rd_ptr + AW'(1);
            end
            out_load = 1'b1;
            o_pix    = rdata;
            o_eol    = eol_next;
            o_done   = done;
            o_last   = last_byte && !cross_q;
          end
        end else if (remain != '0) begin
          req.re      = 1'b1;
          req.raddr   = rd_ptr;
          rd_ptr_next = rd_ptr + AW'(1);
          busy_next   = 1'b1;
        end
      end
      ST_TAIL: begin
        if (can_load) begin
          out_load   = 1'b1;
          o_status   = tail_status;
          state_next = ST_STOP;
        end
      end
      ST_STOP: begin
      end
      default: begin
        state_next = ST_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CODE;
      wp          <= '0;
      pending     <= '0;
      line_pos    <= '0;
      line_idx    <= '0;
      consumed    <= '0;
      remain      <= '0;
      cross_q     <= 1'b0;
      busy        <= 1'b0;
      tail_status <= lzd_pkg::STATUS_DATA;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      wp          <= wp_next;
      pending     <= pending_next;
      line_pos    <= line_pos_next;
      line_idx    <= line_idx_next;
      consumed    <= consumed_next;
      remain      <= remain_next;
      cross_q     <= cross_next;
      busy        <= busy_next;
      tail_status <= tail_status_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    if (out_load) begin
      out_pix    <= o_pix;
      out_eol    <= o_eol;
      out_done   <= o_done;
      out_status <= o_status;
      out_cons   <= consumed_next;
      out_last   <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_line <= 16'd1;
      line_count     <= 16'd1;
    end else if (cfg_we) begin
      unique case (lzd_pkg::reg_index_t'(cfg_index))
        lzd_pkg::REG_BYTES_PER_LINE: bytes_per_line <= cfg_data;
        lzd_pkg::REG_LINE_COUNT:     line_count     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pixels.valid          = out_valid;
  assign pixels.pixel_byte     = out_pix;
  assign pixels.end_of_line    = out_eol;
  assign pixels.image_done     = out_done;
  assign pixels.status         = out_status;
  assign pixels.consumed_bytes = out_cons;
  assign pixels.last           = out_last;

endmodule

/* sv/lzd_check.sv */
// Port-level assertions for the image line decompressor and their bind.
module lzd_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   pixel_byte,
  input logic                         image_done,
  input logic [1:0]                   status,
  input logic [lzd_pkg::COUNT_W-1:0]  consumed_bytes,
  input logic                         last
);

  logic                        stopped;
  logic                        seen;
  logic [lzd_pkg::COUNT_W-1:0] prev_cons;
  logic                        out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped   <= 1'b0;
      seen      <= 1'b0;
      prev_cons <= '0;
    end else if (out_fire) begin
      seen      <= 1'b1;
      prev_cons <= consumed_bytes;
      if (status != lzd_pkg::STATUS_DATA || image_done) begin
        stopped <= 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_byte) && $stable(status)
                                && $stable(consumed_bytes) && $stable(last))
    else $error("result changed while stalled");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !out_valid)
    else $error("result after image end or error");

  a_mono: assert property (@(posedge clk) disable iff (rst)
    out_fire && seen |-> consumed_bytes >= prev_cons)
    else $error("consumed count went backward");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lz_image_line_decompressor lzd_check u_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (pixels.valid),
  .out_ready      (pixels.ready),
  .pixel_byte     (pixels.pixel_byte),
  .image_done     (pixels.image_done),
  .status         (pixels.status),
  .consumed_bytes (pixels.consumed_bytes),
  .last           (pixels.last)
);
